// ----- design/scnp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the short-name check and pack block: item types, constants, byte class.
package scnp_pkg;

  localparam int BASE_LEN = 8;
  localparam int EXT_LEN  = 3;

  localparam int BASE_CNT_W = $clog2(BASE_LEN + 1);
  localparam int EXT_CNT_W  = $clog2(EXT_LEN + 1);

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CASE_OFFSET = 8'h20;  // 'a' - 'A'

  localparam logic [63:0] SPACE8 = {8{CHAR_SPACE}};
  localparam logic [23:0] SPACE3 = {3{CHAR_SPACE}};

  typedef struct packed {
    logic [7:0] ch;
    logic       end_item;
  } scnp_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] base_chars;
    logic [23:0] ext_chars;
  } scnp_out_t;

  // raise a..z to upper case
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

  // DOS short-name character set, upper-cased input expected
  function automatic logic legal_byte(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (c >= 8'h80) ok = 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
    case (c)
      8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60, 8'h21,
      8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26, 8'h20: ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

endpackage

// ----- design/scnp_in_stage.sv -----
`timescale 1ns / 1ps
// Input register: holds one item until the scan stage takes it.
module scnp_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  scnp_pkg::scnp_in_t item,
  input  logic               take,
  output logic               full,
  output scnp_pkg::scnp_in_t held
);
  import scnp_pkg::*;

  logic accept;
  logic full_next;

  assign item_stall = full && !take;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    full_next = full;
    if (accept) begin
      full_next = 1'b1;
    end else if (take) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item;
    end
  end

endmodule

// ----- design/scnp_scan.sv -----
`timescale 1ns / 1ps
// Scan stage: classifies each byte, updates counts and buffers, forms the result.
module scnp_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  scnp_pkg::scnp_in_t  item,
  output scnp_pkg::scnp_out_t result
);
  import scnp_pkg::*;

  logic [63:0]           base_buf,    base_buf_next;
  logic [23:0]           ext_buf,     ext_buf_next;
  logic [BASE_CNT_W-1:0] base_count,  base_count_next;
  logic [EXT_CNT_W-1:0]  ext_count,   ext_count_next;
  logic                  seen_dot,    seen_dot_next;
  logic                  bad_flag,    bad_flag_next;
  logic                  after_slash, after_slash_next;
  logic [7:0]            uc;

  assign uc = to_upper(item.ch);

  // result as it stands; only used on an end item
  always_comb begin
    result.valid_res  = !bad_flag;
    result.base_chars = bad_flag ? 64'd0 : base_buf;
    result.ext_chars  = bad_flag ? 24'd0 : ext_buf;
  end

  always_comb begin
    base_buf_next    = base_buf;
    ext_buf_next     = ext_buf;
    base_count_next  = base_count;
    ext_count_next   = ext_count;
    seen_dot_next    = seen_dot;
    bad_flag_next    = bad_flag;
    after_slash_next = after_slash;
    if (step) begin
      if (item.end_item) begin
        base_buf_next    = SPACE8;
        ext_buf_next     = SPACE3;
        base_count_next  = '0;
        ext_count_next   = '0;
        seen_dot_next    = 1'b0;
        bad_flag_next    = 1'b0;
        after_slash_next = 1'b0;
      end else if (!after_slash && !bad_flag) begin
        if (item.ch == CHAR_SLASH || item.ch == CHAR_NUL) begin
          after_slash_next = 1'b1;
        end else if (item.ch == CHAR_DOT) begin
          if (seen_dot) begin
            bad_flag_next = 1'b1;
          end else begin
            seen_dot_next = 1'b1;
          end
        end else if (!legal_byte(uc)) begin
          bad_flag_next = 1'b1;
        end else if (!seen_dot) begin
          if (base_count < BASE_CNT_W'(BASE_LEN)) begin
            for (int i = 0; i < BASE_LEN; i++) begin
              if (base_count == BASE_CNT_W'(i)) begin
                base_buf_next[i*8 +: 8] = uc;
              end
            end
            base_count_next = base_count + BASE_CNT_W'(1);
          end else begin
            bad_flag_next = 1'b1;
          end
        end else if (base_count == '0) begin
          bad_flag_next = 1'b1;
        end else if (ext_count < EXT_CNT_W'(EXT_LEN)) begin
          for (int i = 0; i < EXT_LEN; i++) begin
            if (ext_count == EXT_CNT_W'(i)) begin
              ext_buf_next[i*8 +: 8] = uc;
            end
          end
          ext_count_next = ext_count + EXT_CNT_W'(1);
        end else begin
          bad_flag_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_buf    <= SPACE8;
      ext_buf     <= SPACE3;
      base_count  <= '0;
      ext_count   <= '0;
      seen_dot    <= 1'b0;
      bad_flag    <= 1'b0;
      after_slash <= 1'b0;
    end else begin
      base_buf    <= base_buf_next;
      ext_buf     <= ext_buf_next;
      base_count  <= base_count_next;
      ext_count   <= ext_count_next;
      seen_dot    <= seen_dot_next;
      bad_flag    <= bad_flag_next;
      after_slash <= after_slash_next;
    end
  end

endmodule

// ----- design/scnp_out_stage.sv -----
`timescale 1ns / 1ps
// Result register with valid/stall handshake.
module scnp_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  scnp_pkg::scnp_out_t data,
  output logic                res_valid,
  input  logic                res_stall,
  output scnp_pkg::scnp_out_t res,
  output logic                free
);
  import scnp_pkg::*;

  logic res_valid_next;

  assign free = !res_valid || !res_stall;

  always_comb begin
    res_valid_next = res_valid;
    if (load) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= data;
    end
  end

endmodule

// ----- design/short_name_check_and_pack.sv -----
`timescale 1ns / 1ps
// Top level: DOS 8.3 short-name checker and packer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   item    | in        | item_valid / item_stall | ch, end_item (scnp_in_t)
//   res     | out       | res_valid / res_stall   | valid_res, base_chars,
//           |           |                         | ext_chars (scnp_out_t)
//
// One byte item per cycle is sustained while no end item is held back.
// res_valid rises once the end item has moved from the input register into
// the output register. An end item waits in the input register only while a
// result is held stalled in the output register; a byte item there never does.
// Synchronous reset clears the handshake state and the scan state (empty name).
module short_name_check_and_pack (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  scnp_pkg::scnp_in_t  item,
  output logic                res_valid,
  input  logic                res_stall,
  output scnp_pkg::scnp_out_t res
);
  import scnp_pkg::*;

  logic      full;
  scnp_in_t  held;
  logic      take;
  logic      out_free;
  scnp_out_t result;

  // byte items always move on; an end item needs room in the result register
  assign take = full && (!held.end_item || out_free);

  scnp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .take       (take),
    .full       (full),
    .held       (held)
  );

  scnp_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (take),
    .item   (held),
    .result (result)
  );

  scnp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && held.end_item),
    .data      (result),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .free      (out_free)
  );

endmodule

// ----- design/scnp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the short-name block, bound to the top level.
module scnp_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input scnp_pkg::scnp_in_t  item,
  input logic                res_valid,
  input logic                res_stall,
  input scnp_pkg::scnp_out_t res
);
  import scnp_pkg::*;

  // held result stays put while stalled
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // offered item stays put while stalled
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("input item changed while stalled");

  // a rejected name carries zero bytes
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.valid_res |-> res.base_chars == 64'd0 && res.ext_chars == 24'd0)
    else $error("invalid result with nonzero bytes");

  // input only backs up behind a held result
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !item_stall)
    else $error("input stalled with empty output");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind short_name_check_and_pack scnp_checker u_scnp_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .item       (item),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res        (res)
);

// ----- dv/short_name_result_checker.sv -----
`timescale 1ns / 1ps
// Checker for the short-name block: watches both channels, predicts each name, compares.
module short_name_result_checker
  import scnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  scnp_in_t    item,
  input  logic        res_valid,
  input  logic        res_stall,
  input  scnp_out_t   res,
  output int unsigned mismatches,
  output int unsigned names_owed,
  output int unsigned names_seen,
  output int unsigned names_legal
);

  // 8.3 names predicted for end items not yet answered, oldest first
  scnp_out_t expected_names[$];

  // scan state of the name being received
  logic [63:0] base_bytes;
  logic [23:0] ext_bytes;
  int          base_len;
  int          ext_len;
  logic        dot_seen;
  logic        name_bad;
  logic        name_closed;

  int unsigned mismatch_count = 0;
  int unsigned owed_count     = 0;
  int unsigned seen_count     = 0;
  int unsigned legal_count    = 0;

  assign mismatches  = mismatch_count;
  assign names_owed  = owed_count;
  assign names_seen  = seen_count;
  assign names_legal = legal_count;

  localparam string DOS_PUNCT = "$%'-_@~!(){}^#& ";

  function automatic logic dos_char(input logic [7:0] c);
    logic hit;
    hit = (c >= 8'h80) || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") || (c == 8'h60);
    for (int i = 0; i < DOS_PUNCT.len(); i++) begin
      if (c == DOS_PUNCT[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic clear_name();
    base_bytes  = SPACE8;
    ext_bytes   = SPACE3;
    base_len    = 0;
    ext_len     = 0;
    dot_seen    = 1'b0;
    name_bad    = 1'b0;
    name_closed = 1'b0;
  endtask

  task automatic scan_name_byte(input logic [7:0] c);
    logic [7:0] up;
    if (name_closed || name_bad) return;
    if (c == CHAR_SLASH || c == CHAR_NUL) begin
      name_closed = 1'b1;
      return;
    end
    if (c == CHAR_DOT) begin
      if (dot_seen) name_bad = 1'b1;
      else dot_seen = 1'b1;
      return;
    end
    up = (c >= "a" && c <= "z") ? c - CASE_OFFSET : c;
    if (!dos_char(up)) begin
      name_bad = 1'b1;
    end else if (!dot_seen) begin
      if (base_len < BASE_LEN) begin
        base_bytes[base_len*8 +: 8] = up;
        base_len++;
      end else begin
        name_bad = 1'b1;
      end
    end else if (base_len == 0 || ext_len >= EXT_LEN) begin
      // extension on an empty name, or extension too long
      name_bad = 1'b1;
    end else begin
      ext_bytes[ext_len*8 +: 8] = up;
      ext_len++;
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH %0d at %0t ns: %s got %h want %h", mismatch_count, $time, what, got,
             want);
  endtask

  initial clear_name();

  always @(posedge clk) begin
    scnp_out_t want;
    scnp_out_t packed_name;
    if (rst) begin
      clear_name();
    end else begin
      // compare before predicting: a result never belongs to an end item of this edge
      if (res_valid && !res_stall) begin
        seen_count++;
        if (expected_names.size() == 0) begin
          report("result with nothing owed, base_chars", res.base_chars, '0);
        end else begin
          want = expected_names.pop_front();
          if (res.valid_res !== want.valid_res)
            report("valid_res", 64'(res.valid_res), 64'(want.valid_res));
          if (res.base_chars !== want.base_chars)
            report("base_chars", res.base_chars, want.base_chars);
          if (res.ext_chars !== want.ext_chars)
            report("ext_chars", 64'(res.ext_chars), 64'(want.ext_chars));
          if (want.valid_res) legal_count++;
        end
      end
      if (item_valid && !item_stall) begin
        if (item.end_item) begin
          if (name_bad) begin
            packed_name = '0;
          end else begin
            packed_name.valid_res  = 1'b1;
            packed_name.base_chars = base_bytes;
            packed_name.ext_chars  = ext_bytes;
          end
          expected_names.push_back(packed_name);
          clear_name();
        end else begin
          scan_name_byte(item.ch);
        end
      end
      owed_count = expected_names.size();
    end
  end

endmodule

// ----- dv/short_name_check_and_pack_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the short-name check and pack block: stimulus, back pressure, verdict.
module short_name_check_and_pack_test;
  import scnp_pkg::*;

  localparam int    ITEM_TARGET    = 550;
  localparam int    QUIET_LIMIT    = 2000;  // cycles with no handshake before giving up
  localparam int    SQUEEZE_CYCLES = 80;    // long receiver hold-off
  localparam int    DRAIN_CYCLES   = 8;     // margin once nothing is owed
  localparam string DOS_PUNCT      = "$%'-_@~!(){}^#& ";

  logic      clk        = 1'b0;
  logic      rst        = 1'b1;
  logic      item_valid = 1'b0;
  scnp_in_t  item       = '0;
  logic      res_stall  = 1'b0;
  logic      item_stall;
  logic      res_valid;
  scnp_out_t res;

  int unsigned mismatches;
  int unsigned names_owed;
  int unsigned names_seen;
  int unsigned names_legal;

  // phase controls, written by the stimulus process but for squeeze_done and quiet_cycles
  logic steady_phase = 1'b0;   // no idling on either side
  int   squeeze_req  = 0;
  int   squeeze_done = 0;      // written by the receiver only
  int   items_sent   = 0;
  int   quiet_cycles = 0;

  short_name_check_and_pack uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  short_name_result_checker name_check (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res),
    .mismatches  (mismatches),
    .names_owed  (names_owed),
    .names_seen  (names_seen),
    .names_legal (names_legal)
  );

  initial begin
    forever begin
      #6 clk = ~clk;
    end
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls about 29% of cycles, none in the steady phase.
  // On request it holds off for SQUEEZE_CYCLES so the output register fills
  // and an end item backs up into the input register.
  initial begin
    forever begin
      @(posedge clk);
      if (squeeze_req != squeeze_done) begin
        res_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done++;
      end
      res_stall <= !steady_phase && ($urandom_range(99) < 29);
    end
  end

  // Offer one item; random idle gaps first, then hold until accepted.
  // valid stays high into the next call, so a back-to-back item never
  // sees valid dropped and raised in the same step.
  task automatic offer_item(input logic [7:0] c, input logic is_end);
    while (!steady_phase && $urandom_range(99) < 29) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= '{ch: c, end_item: is_end};
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  // Name bytes from a string, then the end item (its ch is don't-care, so random).
  task automatic send_name(input string s);
    for (int i = 0; i < s.len(); i++) offer_item(s[i], 1'b0);
    offer_item(8'($urandom), 1'b1);
  endtask

  // A byte from the DOS short-name set, lower case included.
  function automatic logic [7:0] dos_byte();
    int pick;
    pick = $urandom_range(DOS_PUNCT.len());
    case ($urandom_range(4))
      0:       return 8'("a" + $urandom_range(25));
      1:       return 8'("A" + $urandom_range(25));
      2:       return 8'("0" + $urandom_range(9));
      3:       return 8'(8'h80 + $urandom_range(127));
      default: return (pick == DOS_PUNCT.len()) ? 8'h60 : DOS_PUNCT[pick];
    endcase
  endfunction

  // Mostly well-formed names with random content, sometimes a bit too long,
  // a stray dot or a closing slash or zero byte; the rest is raw byte noise.
  task automatic send_random_name();
    int base_n;
    int ext_n;
    int tail_n;
    if ($urandom_range(99) < 75) begin
      base_n = ($urandom_range(9) == 0) ? BASE_LEN + 1 : $urandom_range(BASE_LEN);
      for (int i = 0; i < base_n; i++) offer_item(dos_byte(), 1'b0);
      if ($urandom_range(3) != 0) begin
        offer_item(CHAR_DOT, 1'b0);
        ext_n = ($urandom_range(7) == 0) ? EXT_LEN + 1 : $urandom_range(EXT_LEN);
        for (int i = 0; i < ext_n; i++) begin
          offer_item(($urandom_range(11) == 0) ? CHAR_DOT : dos_byte(), 1'b0);
        end
      end
      if ($urandom_range(9) == 0) begin
        offer_item($urandom_range(1) ? CHAR_SLASH : CHAR_NUL, 1'b0);
        tail_n = $urandom_range(3);
        for (int i = 0; i < tail_n; i++) offer_item(8'($urandom), 1'b0);
      end
    end else begin
      tail_n = $urandom_range(12);
      for (int i = 0; i < tail_n; i++) offer_item(8'($urandom), 1'b0);
    end
    offer_item(8'($urandom), 1'b1);
  endtask

  initial begin
    int name_idx;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed names
    send_name("");          // empty component: legal, all spaces
    send_name(".");         // lone dot: legal, all spaces
    send_name("a..");       // second dot
    send_name(".x");        // extension after an empty name
    offer_item(CHAR_NUL, 1'b0);
    send_name("q");         // zero byte ends the name, q ignored
    send_name("m/n");       // slash ends the name
    send_name("a*.");       // illegal byte, then the dot is ignored
    offer_item(8'hFF, 1'b0);
    send_name("z.e~");      // top byte value, lower case raised

    // random names; a steady stretch and one long receiver hold-off
    name_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      steady_phase <= (name_idx >= 50 && name_idx < 80);
      if (name_idx == 30) squeeze_req <= squeeze_req + 1;
      send_random_name();
      name_idx++;
    end
    item_valid <= 1'b0;

    while (names_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items offered and taken, %0d names returned (%0d legal, %0d rejected)",
             items_sent, names_seen, names_legal, names_seen - names_legal);
    $display("run: random stalls both ways, one steady stretch, one %0d-cycle output hold-off",
             SQUEEZE_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/scnp_pkg.sv
design/scnp_in_stage.sv
design/scnp_scan.sv
design/scnp_out_stage.sv
design/short_name_check_and_pack.sv
design/scnp_checker.sv
dv/short_name_result_checker.sv
dv/short_name_check_and_pack_test.sv
